FILE: hw/rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZW code decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // default sizes
  localparam int TABLE_BITS_DEF     = 12;
  localparam int MAX_STRING_LEN_DEF = 512;

  // special codes and widths
  localparam logic [16:0] CODE_CLEAR = 17'd256;
  localparam logic [16:0] CODE_END   = 17'd257;
  localparam logic [16:0] FIRST_FREE = 17'd258;
  localparam logic [4:0]  MIN_WIDTH  = 5'd9;
  localparam logic [4:0]  MAX_WIDTH  = 5'd16;

  // reset values of the registers
  localparam logic [4:0]  MAX_BITS_RST = 5'd12;
  localparam logic [23:0] LIMIT_RST    = 24'd65536;

  // register indexes
  localparam logic [1:0] REG_MAX_BITS = 2'd0;
  localparam logic [1:0] REG_END_MODE = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_END   = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_KW,
    S_KW_WAIT,
    S_LEN,
    S_WALK,
    S_ADD,
    S_FILL,
    S_SEND
  } state_e;

endpackage

FILE: hw/rtl/lzwd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lzw_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_code_decoder
// LZW code decoder: dictionary in RAM, chain walk into a byte stack, then
// the string leaves in chunks of up to eight bytes.
// ----------------------------------------------------------------------------
// Clear, end, stop and range errors give one result right after the take
// edge; a length error comes from S_LEN, reached through S_KW and S_KW_WAIT
// for a self-referencing code. A string passes S_LEN, S_WALK, S_ADD when an
// entry is added after the walk, and S_FILL before its first beat. The input
// stays stalled until the decoder is back in S_IDLE, so no new code is taken
// while a string is sent. Reset: control registers only, no RAM clear.
module lzw_code_decoder #(
  parameter int TABLE_BITS     = lzwd_pkg::TABLE_BITS_DEF,
  parameter int MAX_STRING_LEN = lzwd_pkg::MAX_STRING_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // code input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [4:0]  next_code_width_o,
  output logic [4:0]  end_code_width_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  import lzwd_pkg::*;

  localparam int TB  = TABLE_BITS;
  localparam int LW  = $clog2(MAX_STRING_LEN + 2);
  localparam int SAW = $clog2(MAX_STRING_LEN);
  localparam int NW  = TB + 1;
  localparam int DW  = TB + 8 + LW;

  state_e state_q, state_d;

  logic [4:0]    mcb_q, mcb_d;
  logic          ecm_q, ecm_d;
  logic [23:0]   bl_q, bl_d;
  logic [NW-1:0] nfc_q, nfc_d;
  logic [4:0]    cw_q, cw_d;
  logic [TB-1:0] prev_q, prev_d;
  logic          prev_v_q, prev_v_d;
  logic [7:0]    pfb_q, pfb_d;
  logic          jg_q, jg_d;
  logic          stop_q, stop_d;
  logic          ov_q, ov_d;

  logic [TB-1:0]  code_q, code_d;
  logic           kw_q, kw_d;
  logic [LW-1:0]  len_q, len_d;
  logic [TB-1:0]  c_q, c_d;
  logic [SAW-1:0] i_q, i_d;
  logic [LW-1:0]  rp_q, rp_d;
  logic [LW-1:0]  got_q, got_d;
  logic [3:0]     cnt_q, cnt_d;
  logic           pend_q, pend_d;
  logic [63:0]    chunk_q, chunk_d;
  logic [63:0]    ob_q, ob_d;
  logic [3:0]     oc_q, oc_d;
  logic           ol_q, ol_d;
  logic [2:0]     os_q, os_d;

  // dictionary and stack ports
  logic          d_we;
  logic [TB-1:0] d_waddr, d_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [TB-1:0] d_pre;
  logic [7:0]    d_suf;
  logic [LW-1:0] d_len;

  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [7:0]     s_wdata, s_rdata;

  // ---- shared decode ----
  logic        acc, out_take, cfg_wr;
  logic [16:0] code17, nfc17, alloc, nfc_inc, code_q17, c_q17, prev17;
  logic [4:0]  eff_bits;
  logic        dec_stopped, dec_clear, dec_end, dec_bad, dec_kw_err, dec_kw;
  logic [LW-1:0] plen, newlen, lenv;
  logic        add_ok, grow, len_err;
  logic [7:0]  suf_cur;
  logic        cap, issue, chunk_done;
  logic [3:0]  cnt_n;
  logic [LW-1:0] got_n;

  assign acc      = in_valid_i && !in_stall_o;
  assign out_take = ov_q && !out_stall_i;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;

  assign code17   = {1'b0, code_i};
  assign nfc17    = 17'(nfc_q);
  assign code_q17 = 17'(code_q);
  assign c_q17    = 17'(c_q);
  assign prev17   = 17'(prev_q);
  assign nfc_inc  = nfc17 + 17'd1;

  // effective dictionary size
  always_comb begin
    if (mcb_q < MIN_WIDTH) begin
      eff_bits = MIN_WIDTH;
    end else if (mcb_q > 5'(TB)) begin
      eff_bits = 5'(TB);
    end else begin
      eff_bits = mcb_q;
    end
  end
  assign alloc = 17'd1 << eff_bits;

  // classification of an incoming code
  assign dec_stopped = stop_q || (bl_q == 24'd0);
  assign dec_clear   = (code17 == CODE_CLEAR);
  assign dec_end     = ecm_q && (code17 == CODE_END);
  assign dec_bad     = (code17 >= alloc) || (code17 > nfc17);
  assign dec_kw_err  = (code17 == nfc17) && !prev_v_q;
  assign dec_kw      = (code17 == nfc17);

  // dictionary entry fields
  assign d_pre = d_rdata[DW-1 -: TB];
  assign d_suf = d_rdata[LW +: 8];
  assign d_len = d_rdata[LW-1:0];

  // new entry built from the previous code
  assign plen   = (prev17 < CODE_CLEAR) ? LW'(1) : d_len;
  assign newlen = (plen >= LW'(MAX_STRING_LEN)) ? LW'(MAX_STRING_LEN + 1) : plen + LW'(1);
  assign add_ok = nfc17 < alloc;
  assign grow   = (cw_q < MAX_WIDTH) && (nfc_inc >= (17'd1 << cw_q)) && (nfc_inc < alloc);

  // string length of the current code
  always_comb begin
    if (code_q17 < CODE_CLEAR) begin
      lenv = LW'(1);
    end else if (code_q17 < FIRST_FREE) begin
      lenv = '0;
    end else begin
      lenv = d_len;
    end
  end
  assign len_err = (lenv == '0) || (lenv > LW'(MAX_STRING_LEN)) ||
                   (24'(lenv) > bl_q);

  assign suf_cur = (c_q17 < CODE_CLEAR) ? c_q[7:0] : d_suf;

  // chunk assembly from the stack read port
  assign cap        = pend_q;
  assign issue      = (rp_q < len_q) && ((cnt_q + {3'b000, pend_q}) < 4'd8);
  assign cnt_n      = cnt_q + {3'b000, cap};
  assign got_n      = got_q + LW'(cap);
  assign chunk_done = (cnt_n == 4'd8) || (got_n == len_q);

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && !dec_stopped && !dec_clear && !dec_end && !dec_bad &&
            !dec_kw_err) begin
          state_d = dec_kw ? S_KW : S_LEN;
        end
      end
      S_KW:      state_d = S_KW_WAIT;
      S_KW_WAIT: state_d = S_LEN;
      S_LEN:     state_d = len_err ? S_IDLE : S_WALK;
      S_WALK: begin
        if (i_q == '0) begin
          state_d = (!kw_q && prev_v_q) ? S_ADD : S_FILL;
        end
      end
      S_ADD:  state_d = S_FILL;
      S_FILL: begin
        if (chunk_done) begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (out_take) begin
          state_d = ol_q ? S_IDLE : S_FILL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---- datapath and outputs ----
  always_comb begin
    mcb_d    = mcb_q;
    ecm_d    = ecm_q;
    bl_d     = bl_q;
    nfc_d    = nfc_q;
    cw_d     = cw_q;
    prev_d   = prev_q;
    prev_v_d = prev_v_q;
    pfb_d    = pfb_q;
    jg_d     = jg_q;
    stop_d   = stop_q;
    ov_d     = ov_q && out_stall_i;
    code_d   = code_q;
    kw_d     = kw_q;
    len_d    = len_q;
    c_d      = c_q;
    i_d      = i_q;
    rp_d     = rp_q;
    got_d    = got_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    chunk_d  = chunk_q;
    ob_d     = ob_q;
    oc_d     = oc_q;
    ol_d     = ol_q;
    os_d     = os_q;
    d_we     = 1'b0;
    d_waddr  = nfc_q[TB-1:0];
    d_wdata  = {prev_q, pfb_q, newlen};
    d_raddr  = code_q;
    s_we     = 1'b0;
    s_waddr  = i_q;
    s_wdata  = suf_cur;
    s_raddr  = rp_q[SAW-1:0];

    case (state_q)
      S_IDLE: begin
        d_raddr = code_i[TB-1:0];
        if (acc) begin
          code_d = code_i[TB-1:0];
          ob_d   = '0;
          oc_d   = '0;
          ol_d   = 1'b1;
          if (dec_stopped) begin
            ov_d = 1'b1;
            os_d = (bl_q == 24'd0) ? ST_DONE : ST_ERR;
          end else if (dec_clear) begin
            ov_d     = 1'b1;
            os_d     = ST_CLEAR;
            cw_d     = MIN_WIDTH;
            nfc_d    = NW'(FIRST_FREE);
            prev_v_d = 1'b0;
            jg_d     = 1'b0;
          end else if (dec_end) begin
            ov_d   = 1'b1;
            os_d   = ST_END;
            stop_d = 1'b1;
          end else begin
            jg_d = 1'b0;
            if (dec_bad || dec_kw_err) begin
              ov_d   = 1'b1;
              os_d   = ST_ERR;
              stop_d = 1'b1;
            end else if (dec_kw) begin
              kw_d    = 1'b1;
              d_raddr = prev_q;
            end else begin
              kw_d = 1'b0;
            end
          end
        end
      end
      S_KW, S_ADD: begin
        // append previous string plus first byte
        if (add_ok) begin
          d_we  = 1'b1;
          nfc_d = nfc_q + NW'(1);
          if (grow) begin
            cw_d = cw_q + 5'd1;
            jg_d = 1'b1;
          end
        end
        prev_d   = code_q;
        prev_v_d = 1'b1;
      end
      S_LEN: begin
        if (len_err) begin
          ov_d   = 1'b1;
          ob_d   = '0;
          oc_d   = '0;
          ol_d   = 1'b1;
          os_d   = ST_ERR;
          stop_d = 1'b1;
        end else begin
          bl_d    = bl_q - 24'(lenv);
          stop_d  = (bl_q == 24'(lenv));
          len_d   = lenv;
          i_d     = SAW'(lenv - LW'(1));
          c_d     = code_q;
          rp_d    = '0;
          got_d   = '0;
          cnt_d   = '0;
          pend_d  = 1'b0;
          chunk_d = '0;
        end
      end
      S_WALK: begin
        // one chain entry per cycle, bytes land in reverse order
        s_we = 1'b1;
        if (i_q == '0) begin
          pfb_d = suf_cur;
          if (!kw_q && prev_v_q) begin
            d_raddr = prev_q;
          end else if (!kw_q) begin
            prev_d   = code_q;
            prev_v_d = 1'b1;
          end
        end else begin
          c_d     = d_pre;
          d_raddr = d_pre;
          i_d     = i_q - SAW'(1);
        end
      end
      S_FILL: begin
        if (cap) begin
          chunk_d[{cnt_q[2:0], 3'b000} +: 8] = s_rdata;
        end
        cnt_d  = cnt_n;
        got_d  = got_n;
        pend_d = issue;
        if (issue) begin
          rp_d = rp_q + LW'(1);
        end
        if (chunk_done) begin
          ov_d    = 1'b1;
          ob_d    = chunk_d;
          oc_d    = cnt_n;
          ol_d    = (got_n == len_q);
          os_d    = ((got_n == len_q) && (bl_q == 24'd0)) ? ST_DONE : ST_DATA;
          cnt_d   = '0;
          chunk_d = '0;
        end
      end
      S_SEND: begin
      end
      default: begin
      end
    endcase

    // register writes
    if (cfg_wr) begin
      case (cfg_index_i)
        REG_MAX_BITS: mcb_d = cfg_data_i[4:0];
        REG_END_MODE: ecm_d = cfg_data_i[0];
        REG_LIMIT:    bl_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mcb_q    <= MAX_BITS_RST;
      ecm_q    <= 1'b0;
      bl_q     <= LIMIT_RST;
      nfc_q    <= NW'(FIRST_FREE);
      cw_q     <= MIN_WIDTH;
      prev_v_q <= 1'b0;
      pfb_q    <= 8'd0;
      jg_q     <= 1'b0;
      stop_q   <= 1'b0;
      ov_q     <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mcb_q    <= mcb_d;
      ecm_q    <= ecm_d;
      bl_q     <= bl_d;
      nfc_q    <= nfc_d;
      cw_q     <= cw_d;
      prev_v_q <= prev_v_d;
      pfb_q    <= pfb_d;
      jg_q     <= jg_d;
      stop_q   <= stop_d;
      ov_q     <= ov_d;
      pend_q   <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    code_q  <= code_d;
    kw_q    <= kw_d;
    len_q   <= len_d;
    c_q     <= c_d;
    i_q     <= i_d;
    rp_q    <= rp_d;
    got_q   <= got_d;
    cnt_q   <= cnt_d;
    chunk_q <= chunk_d;
    ob_q    <= ob_d;
    oc_q    <= oc_d;
    ol_q    <= ol_d;
    os_q    <= os_d;
  end

  // dictionary: prefix, suffix, length
  lzwd_ram #(
    .WIDTH (DW),
    .DEPTH (1 << TB)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // reverse byte stack
  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (1 << SAW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // ports
  assign in_stall_o        = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = ov_q;
  assign out_bytes_o       = ob_q;
  assign byte_count_o      = oc_q;
  assign last_o            = ol_q;
  assign status_o          = os_q;
  assign next_code_width_o = cw_q;
  assign end_code_width_o  = (ecm_q && jg_q) ? (cw_q - 5'd1) : cw_q;

  // ---- assertions ----
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (LW'(i_q) < len_q))
    else $error("stack write beyond string length");

  a_send_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND) |-> ov_q)
    else $error("send state without a result");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (os_q == ST_DATA)) |-> ((oc_q != 4'd0) && (oc_q <= 4'd8)))
    else $error("data chunk with bad byte count");

  a_budget_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> (bl_q <= $past(bl_q)))
    else $error("byte budget grew without a register write");

endmodule
